// ===== rtl/core/lspd_pkg.sv =====
// ----------------------------------------------------------------------------
// lspd_pkg
// Types and constants shared by the scan packet decoder modules.
// ----------------------------------------------------------------------------
package lspd_pkg;

    // Byte positions within a scan packet
    localparam logic [7:0] POS_COUNT      = 8'd3;
    localparam logic [7:0] POS_START_HIGH = 8'd5;
    localparam logic [7:0] POS_END_HIGH   = 8'd7;
    localparam logic [7:0] POS_FIRST_DIST = 8'd11;

    localparam logic [15:0] NEAR_LIMIT_RESET = 16'd1600;

    // Arithmetic widths: |end-start| is 15 bits, k at most 7 bits
    localparam int ANGLE_W = 15;
    localparam int K_W     = 7;
    localparam int PROD_W  = ANGLE_W + K_W;
    localparam int DIV_W   = 8;
    localparam int ITER_W  = $clog2(PROD_W);

    // Zone bounds in 1/64 degree units
    localparam logic [ANGLE_W-1:0] DEG_30  = 15'd1920;
    localparam logic [ANGLE_W-1:0] DEG_40  = 15'd2560;
    localparam logic [ANGLE_W-1:0] DEG_70  = 15'd4480;
    localparam logic [ANGLE_W-1:0] DEG_290 = 15'd18560;
    localparam logic [ANGLE_W-1:0] DEG_320 = 15'd20480;
    localparam logic [ANGLE_W-1:0] DEG_330 = 15'd21120;
    localparam logic [ANGLE_W-1:0] DEG_360 = 15'd23040;

    // Obstacle zone codes
    localparam logic [2:0] ZONE_CLEAR       = 3'd0;
    localparam logic [2:0] ZONE_FRONT_RIGHT = 3'd1;
    localparam logic [2:0] ZONE_FRONT_LEFT  = 3'd2;
    localparam logic [2:0] ZONE_SIDE_RIGHT  = 3'd3;
    localparam logic [2:0] ZONE_SIDE_LEFT   = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] position;
    } t_in_word;

    typedef struct packed {
        logic [5:0]         sample_index;
        logic [ANGLE_W-1:0] angle;
        logic [15:0]        distance_raw;
        logic [2:0]         zone;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_step;
        logic sum_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sample_hit;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/lspd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lspd_ctrl
// Sequencer for the decoder: accept, multiply, divide loop, sum, output.
// ----------------------------------------------------------------------------
module lspd_ctrl import lspd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.sample_hit) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum_load = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lspd_dp.sv =====
// ----------------------------------------------------------------------------
// lspd_dp
// Packet fields, angle interpolation arithmetic, zone check, output register.
// ----------------------------------------------------------------------------
module lspd_dp import lspd_pkg::*; #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_in_word  i_in_word,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic [15:0]        r_near_limit;
    logic [7:0]         r_count;
    logic [ANGLE_W-1:0] r_start;
    logic [ANGLE_W-1:0] r_end;
    logic [7:0]         r_held;

    logic [K_W-1:0]     r_k;
    logic [15:0]        r_dist;
    logic               r_neg;
    logic               r_single;
    logic [DIV_W-1:0]   r_divisor;
    logic [DIV_W-1:0]   r_rem;
    logic [PROD_W-1:0]  r_quo;
    logic [ITER_W-1:0]  r_iter;
    logic [ANGLE_W-1:0] r_angle;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic [7:0]         pos_off;
    logic [K_W-1:0]     k_in;
    logic [15:0]        word16;
    logic [15:0]        diff;
    logic [15:0]        diff_mag;
    logic [DIV_W:0]     rem_sh;
    logic               rem_ge;
    logic [DIV_W:0]     rem_sub;
    logic [16:0]        quo_term;
    logic [16:0]        angle_sum;
    logic [2:0]         zone;
    logic               is_near;

    assign pos_off = i_in_word.position - POS_FIRST_DIST;
    assign k_in    = pos_off[7:1];
    assign word16  = {i_in_word.rx_byte, r_held};

    assign o_sts.sample_hit = i_in_word.position[0]
                            && (i_in_word.position >= POS_FIRST_DIST)
                            && ({1'b0, k_in} < r_count)
                            && ({1'b0, k_in} < 8'(MAX_SAMPLES));
    assign o_sts.div_last   = (r_iter == '0);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // Header fields and the held low byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_limit <= NEAR_LIMIT_RESET;
            r_count      <= '0;
            r_start      <= '0;
            r_end        <= '0;
            r_held       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_near_limit <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                case (i_in_word.position)
                    POS_COUNT:      r_count <= i_in_word.rx_byte;
                    POS_START_HIGH: r_start <= word16[15:1];
                    POS_END_HIGH:   r_end   <= word16[15:1];
                    default: begin
                    end
                endcase
                r_held <= i_in_word.rx_byte;
            end
        end
    end

    // Sign-magnitude multiply, then restoring divide one bit per step
    assign diff     = {1'b0, r_end} - {1'b0, r_start};
    assign diff_mag = diff[15] ? (16'd0 - diff) : diff;
    assign rem_sh   = {r_rem, r_quo[PROD_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_divisor});
    assign rem_sub  = rem_sh - {1'b0, r_divisor};
    assign quo_term = r_single ? 17'd0 : {1'b0, r_quo[15:0]};
    assign angle_sum = {2'b00, r_start} + (r_neg ? (17'd0 - quo_term) : quo_term);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_k    <= k_in;
            r_dist <= word16;
        end
        if (i_cmd.mul_load) begin
            r_neg     <= diff[15];
            r_single  <= (r_count == 8'd1);
            r_divisor <= r_count - 8'd1;
            r_rem     <= '0;
            r_quo     <= PROD_W'(diff_mag[ANGLE_W-1:0] * r_k);
            r_iter    <= ITER_W'(PROD_W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quo  <= {r_quo[PROD_W-2:0], rem_ge};
            r_iter <= r_iter - 1'b1;
        end
        if (i_cmd.sum_load) begin
            r_angle <= angle_sum[ANGLE_W-1:0];
        end
    end

    // Obstacle zone, first match wins
    always_comb begin
        is_near = (r_dist != 16'd0) && (r_dist < r_near_limit);
        zone    = ZONE_CLEAR;
        if (is_near) begin
            if (r_angle > '0 && r_angle < DEG_30) begin
                zone = ZONE_FRONT_RIGHT;
            end else if (r_angle > DEG_330 && r_angle < DEG_360) begin
                zone = ZONE_FRONT_LEFT;
            end else if (r_angle > DEG_40 && r_angle < DEG_70) begin
                zone = ZONE_SIDE_RIGHT;
            end else if (r_angle > DEG_290 && r_angle < DEG_320) begin
                zone = ZONE_SIDE_LEFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word.sample_index <= r_k[5:0];
            r_out_word.angle        <= r_angle;
            r_out_word.distance_raw <= r_dist;
            r_out_word.zone         <= zone;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/lidar_scan_packet_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_packet_decoder_unit
// Scan packet decoder: distance samples with interpolated angle and zone.
// ----------------------------------------------------------------------------
// Feed one packet byte per input word together with its byte position. Bytes
// that are not the high byte of a distance sample (header, low bytes, samples
// past the packet's sample count or past MAX_SAMPLES) are accepted while the
// sequencer stays idle and give no output word. The high byte of sample k is
// latched and then taken through these steps before the next acceptance:
// multiply (end-start)*k, divide by (count-1) in a restoring divider that
// forms one quotient bit per cycle, add the start angle and load the output
// register. The output register lets a finished word wait while the next
// bytes are accepted; a new sample waits in its last step only if the
// previous word is still unclaimed. The near_limit register (reset 1600,
// quarter mm) may be written at any idle time through i_cfg_we / i_cfg_data.
// ----------------------------------------------------------------------------
module lidar_scan_packet_decoder_unit import lspd_pkg::*; #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: steps one sample through multiply, divide and output
    lspd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: packet fields, arithmetic, zone check, output register
    lspd_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
